@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/ssp_pkg.sv @@
// Types and constants of the servo pulse controller
package ssp_pkg;
	localparam int BYTE_W     = 8;
	localparam int WIDTH_W    = 16;
	localparam int ANGLE_W    = 13;
	localparam int ACCUM_W    = 12;
	localparam int TPD_W      = 8;
	localparam int DOG_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD,
		REG_BASE,
		REG_TPD,
		REG_MID,
		REG_WDOG
	} cfg_reg_t;

	// item kinds
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_BYTE = 1'b1;

	localparam logic [WIDTH_W-1:0] PERIOD_RST = 16'd40000;
	localparam logic [WIDTH_W-1:0] BASE_RST   = 16'd2000;
	localparam logic [TPD_W-1:0]   TPD_RST    = 8'd11;
	localparam logic [WIDTH_W-1:0] MID_RST    = 16'd3000;
	localparam logic [DOG_W-1:0]   WDOG_RST   = 24'd8000000;
	localparam logic [WIDTH_W-1:0] WIDTH_RST  = 16'd2000;
	localparam logic [ACCUM_W-1:0] ANGLE_LIMIT = 12'd3454;

	// ASCII codes
	localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
	localparam logic [BYTE_W-1:0] CH_VTAB    = 8'h0B;
	localparam logic [BYTE_W-1:0] CH_FFEED   = 8'h0C;
	localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;

	typedef enum logic [1:0] {
		PH_BLANK,
		PH_DIGIT,
		PH_STOP
	} parse_phase_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] period_ticks;
		logic [WIDTH_W-1:0] pulse_base;
		logic [TPD_W-1:0]   ticks_per_degree;
		logic [WIDTH_W-1:0] safe_width;
		logic [DOG_W-1:0]   watchdog_ticks;
	} cfg_t;

	// pulse width update from a completed command line
	typedef struct packed {
		logic               load;
		logic [WIDTH_W-1:0] width;
	} width_load_t;
endpackage

@@ src/ssp_ifs.sv @@
// Channel interfaces: input items, results and configuration writes
interface ssp_item_if;
	logic                       valid;
	logic                       ready;
	logic                       command;
	logic [ssp_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, command, rx_byte, input ready);
	modport sink (input valid, command, rx_byte, output ready);
endinterface

interface ssp_result_if;
	logic                              valid;
	logic                              ready;
	logic                              servo_pin;
	logic [ssp_pkg::WIDTH_W-1:0]       pulse_width;
	logic signed [ssp_pkg::ANGLE_W-1:0] last_angle;
	logic                              watchdog_alive;
	logic                              watchdog_fired;

	modport source (output valid, servo_pin, pulse_width, last_angle, watchdog_alive,
		watchdog_fired, input ready);
	modport sink (input valid, servo_pin, pulse_width, last_angle, watchdog_alive,
		watchdog_fired, output ready);
endinterface

interface ssp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ssp_pkg::CFG_IDX_W-1:0]  index;
	logic [ssp_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ src/ssp_parser.sv @@
// Decimal line parser: accumulates the value, on newline loads the width or drops keep-alive
module ssp_parser (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               take,
	input  logic [ssp_pkg::BYTE_W-1:0]         rx_byte,
	input  ssp_pkg::cfg_t                      cfg,
	output ssp_pkg::width_load_t               wload,
	output logic signed [ssp_pkg::ANGLE_W-1:0] angle_next,
	output logic                               alive_next,
	output logic                               alive_cur
);
	import ssp_pkg::*;

	logic [ACCUM_W-1:0]        accum_q, accum_n;
	logic                      minus_q, minus_n;
	parse_phase_t              phase_q, phase_n;
	logic signed [ANGLE_W-1:0] angle_q, angle_n;
	logic                      alive_q, alive_n;

	logic                      is_digit, is_blank, is_sign, in_digits;
	logic [ACCUM_W+TPD_W-1:0]  prod;
	logic [ACCUM_W+TPD_W:0]    width_sum;
	logic [WIDTH_W-1:0]        dec;
	logic signed [ANGLE_W-1:0] mag;

	always_comb begin
		is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
		is_blank = (rx_byte == CH_TAB) || (rx_byte == CH_VTAB) || (rx_byte == CH_FFEED) ||
			(rx_byte == CH_CR) || (rx_byte == CH_SPACE);
		is_sign  = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
		prod      = accum_q * cfg.ticks_per_degree;
		width_sum = {{(ACCUM_W+TPD_W+1-WIDTH_W){1'b0}}, cfg.pulse_base} + {1'b0, prod};
		// accum * 10 + digit
		dec = ({{(WIDTH_W-ACCUM_W){1'b0}}, accum_q} << 3) +
			({{(WIDTH_W-ACCUM_W){1'b0}}, accum_q} << 1) +
			{{(WIDTH_W-4){1'b0}}, rx_byte[3:0]};
		mag = signed'({1'b0, accum_q});
		// a first non-blank that is not a sign is handled as a digit-phase byte at once
		in_digits = (phase_q == PH_DIGIT) || ((phase_q == PH_BLANK) && !is_blank && !is_sign);

		accum_n = accum_q;
		minus_n = minus_q;
		phase_n = phase_q;
		angle_n = angle_q;
		alive_n = alive_q;
		wload   = '0;

		if (take) begin
			if (rx_byte == CH_NEWLINE) begin
				angle_n = minus_q ? -mag : mag;
				if (minus_q && (accum_q != '0)) begin
					alive_n = 1'b0;
				end else begin
					wload.load  = 1'b1;
					wload.width = (width_sum > {{(ACCUM_W+TPD_W+1-WIDTH_W){1'b0}}, {WIDTH_W{1'b1}}})
						? {WIDTH_W{1'b1}} : width_sum[WIDTH_W-1:0];
				end
				accum_n = '0;
				minus_n = 1'b0;
				phase_n = PH_BLANK;
			end else begin
				if ((phase_q == PH_BLANK) && !is_blank) begin
					phase_n = PH_DIGIT;
					if (rx_byte == CH_MINUS)
						minus_n = 1'b1;
				end
				if (in_digits) begin
					if (is_digit)
						accum_n = (dec > {{(WIDTH_W-ACCUM_W){1'b0}}, ANGLE_LIMIT})
							? ANGLE_LIMIT : dec[ACCUM_W-1:0];
					else
						phase_n = PH_STOP;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			minus_q <= 1'b0;
			phase_q <= PH_BLANK;
			angle_q <= '0;
			alive_q <= 1'b1;
		end else begin
			accum_q <= accum_n;
			minus_q <= minus_n;
			phase_q <= phase_n;
			angle_q <= angle_n;
			alive_q <= alive_n;
		end
	end

	assign angle_next = angle_n;
	assign alive_next = alive_n;
	assign alive_cur  = alive_q;
endmodule

@@ src/ssp_pwm.sv @@
// Pulse phase timer and watchdog
module ssp_pwm (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        tick,
	input  ssp_pkg::width_load_t        wload,
	input  logic                        alive,
	input  ssp_pkg::cfg_t               cfg,
	output logic                        pin_next,
	output logic [ssp_pkg::WIDTH_W-1:0] width_next,
	output logic                        fired
);
	import ssp_pkg::*;

	logic               pin_q, pin_n;
	logic [WIDTH_W-1:0] pc_q, pc_n;
	logic [WIDTH_W-1:0] width_q, width_n;
	logic [DOG_W-1:0]   dog_q, dog_n;
	logic [DOG_W-1:0]   dog_base, dog_inc;
	logic [WIDTH_W-1:0] len;

	always_comb begin
		pin_n    = pin_q;
		pc_n     = pc_q;
		width_n  = width_q;
		dog_n    = dog_q;
		dog_base = dog_q;
		dog_inc  = '0;
		len      = '0;
		fired    = 1'b0;

		if (wload.load)
			width_n = wload.width;

		if (tick) begin
			if (pc_q == '0) begin
				// phase boundary
				pin_n = ~pin_q;
				if (pin_n)
					len = width_q;
				else
					len = (cfg.period_ticks > width_q) ? (cfg.period_ticks - width_q) : '0;
				pc_n = (len == '0) ? '0 : (len - 1'b1);
				if (alive)
					dog_base = '0;
			end else begin
				pc_n = pc_q - 1'b1;
			end
			dog_inc = dog_base + 1'b1;
			if (dog_inc >= cfg.watchdog_ticks) begin
				fired   = 1'b1;
				width_n = cfg.safe_width;
				dog_n   = '0;
			end else begin
				dog_n = dog_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q   <= 1'b0;
			pc_q    <= '0;
			width_q <= WIDTH_RST;
			dog_q   <= '0;
		end else begin
			pin_q   <= pin_n;
			pc_q    <= pc_n;
			width_q <= width_n;
			dog_q   <= dog_n;
		end
	end

	assign pin_next   = pin_n;
	assign width_next = width_n;
endmodule

@@ src/serial_servo_pulse_controller_unit.sv @@
// Top level of the servo pulse controller with ASCII command parser
//
//  channel | dir  | carries                                          | handshake
//  --------+------+--------------------------------------------------+-----------
//  item    | sink | command (tick/byte), rx_byte                     | valid/ready
//  result  | src  | servo_pin, pulse_width, last_angle, wd alive/fired | valid/ready
//  cfg     | sink | index (0..4), data (24 bits)                     | valid/ready
//
// One result per request. The request is registered, then parser/timer logic
// runs combinationally into the result register.
// Throughput is one request per clock; a new request is taken while a finished
// result waits, and the pipeline holds only when the result register is full
// and not taken. Configuration is always ready and takes effect next cycle.
// Asynchronous reset restores the register defaults and the line state.
`include "assert_macros.svh"

module serial_servo_pulse_controller_unit (
	input  logic          clk,
	input  logic          arst_n,
	ssp_item_if.sink      item,
	ssp_result_if.source  result,
	ssp_cfg_if.sink       cfg
);
	import ssp_pkg::*;

	// configuration registers
	cfg_t cfg_q;

	// request stage
	logic              valid_s1;
	logic              command_s1;
	logic [BYTE_W-1:0] byte_s1;

	// result stage
	logic                      valid_s2;
	logic                      pin_s2;
	logic [WIDTH_W-1:0]        width_s2;
	logic signed [ANGLE_W-1:0] angle_s2;
	logic                      alive_s2;
	logic                      fired_s2;

	logic                      advance, consume, tick, take;
	width_load_t               wload;
	logic signed [ANGLE_W-1:0] angle_next;
	logic                      alive_next, alive_cur;
	logic                      pin_next, fired;
	logic [WIDTH_W-1:0]        width_next;

	// result register frees when empty or being taken
	assign advance    = !valid_s2 || result.ready;
	assign consume    = valid_s1 && advance;
	assign tick       = consume && (command_s1 == CMD_TICK);
	assign take       = consume && (command_s1 == CMD_BYTE);
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_ticks     <= PERIOD_RST;
			cfg_q.pulse_base       <= BASE_RST;
			cfg_q.ticks_per_degree <= TPD_RST;
			cfg_q.safe_width       <= MID_RST;
			cfg_q.watchdog_ticks   <= WDOG_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PERIOD: cfg_q.period_ticks     <= cfg.data[WIDTH_W-1:0];
				REG_BASE:   cfg_q.pulse_base       <= cfg.data[WIDTH_W-1:0];
				REG_TPD:    cfg_q.ticks_per_degree <= cfg.data[TPD_W-1:0];
				REG_MID:    cfg_q.safe_width       <= cfg.data[WIDTH_W-1:0];
				REG_WDOG:   cfg_q.watchdog_ticks   <= cfg.data[DOG_W-1:0];
				default: ;
			endcase
		end
	end

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			command_s1 <= item.command;
			byte_s1    <= item.rx_byte;
		end
	end

	ssp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.rx_byte    (byte_s1),
		.cfg        (cfg_q),
		.wload      (wload),
		.angle_next (angle_next),
		.alive_next (alive_next),
		.alive_cur  (alive_cur)
	);

	ssp_pwm u_pwm (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick),
		.wload      (wload),
		.alive      (alive_cur),
		.cfg        (cfg_q),
		.pin_next   (pin_next),
		.width_next (width_next),
		.fired      (fired)
	);

	// result register: state after the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			pin_s2   <= pin_next;
			width_s2 <= width_next;
			angle_s2 <= angle_next;
			alive_s2 <= alive_next;
			fired_s2 <= tick && fired;
		end
	end

	assign result.valid          = valid_s2;
	assign result.servo_pin      = pin_s2;
	assign result.pulse_width    = width_s2;
	assign result.last_angle     = angle_s2;
	assign result.watchdog_alive = alive_s2;
	assign result.watchdog_fired = fired_s2;

	// a fired watchdog reports the safe width
	`ASSERT_NEXT(a_fire_mid, clk, arst_n, tick && fired, width_s2 == $past(cfg_q.safe_width))
	// keep-alive, once dropped, stays dropped
	`ASSERT_NEXT(a_alive_sticky, clk, arst_n, !alive_cur, !alive_cur)
	// an empty request stage always takes a request
	`ASSERT_IMPLIES(a_ready_empty, clk, arst_n, !valid_s1, item.ready)
	// parsed value stays within its saturation bounds
	`ASSERT_IMPLIES(a_angle_range, clk, arst_n, valid_s2,
		(angle_s2 <= 13'sd3454) && (angle_s2 >= -13'sd3454))
endmodule
